[src/baro_temp_pressure_compensation_defines.svh]
// Assertion macros for the barometric compensation block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/btpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, codes and helpers of the barometric compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RawW  = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  // operation codes
  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TEMP_CAL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_12 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_34 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_56 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_78 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_9  = 3'd5;

  // constants of the compensation
  localparam logic [WordW-1:0] K_TOFFS   = 32'd64000;
  localparam logic [WordW-1:0] K_PBASE   = 32'd1048576;
  localparam logic [WordW-1:0] K_PSCALE  = 32'd3125;
  localparam logic [WordW-1:0] K_SIGN    = 32'h8000_0000;
  localparam logic [WordW-1:0] K_HALF    = 32'd32768;
  localparam logic [WordW-1:0] K_ROUND   = 32'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT,
    ST_DONE
  } state_e;

  // sequencer steps: temperature then pressure
  typedef enum logic [3:0] {
    S_T0, S_T1, S_T2, S_T3,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
    S_P6, S_P7, S_P8, S_P9, S_P10, S_P11
  } step_e;

  // control of a serial arithmetic unit
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } unit_req_t;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x,
                                           input logic [4:0] n);
    asr = WordW'($signed(x) >>> n);
  endfunction

  function automatic logic [WordW-1:0] sext16(input logic [15:0] x);
    sext16 = {{16{x[15]}}, x};
  endfunction

endpackage

[src/btpc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc channel interfaces
// Input, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [19:0] raw_sample;
  modport source (output valid, operation, raw_sample, input ready);
  modport sink   (input valid, operation, raw_sample, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_pa;
  logic               zero_divisor;
  modport source (output valid, temperature_centi, pressure_pa, zero_divisor, input ready);
  modport sink   (input valid, temperature_centi, pressure_pa, zero_divisor, output ready);
endinterface

interface btpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/btpc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_mul
// Bit-serial 32x32 multiplier, low 32 bits of the product, one bit a cycle.
// ----------------------------------------------------------------------------
module btpc_mul
  import btpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  output logic             done_o,
  output logic [WordW-1:0] prod_o
);

  logic [WordW-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // shift-add step
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = {a_q[WordW-2:0], 1'b0};
      b_d   = {1'b0, b_q[WordW-1:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[src/btpc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_div
// Restoring unsigned 32/32 divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module btpc_div
  import btpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  output logic             done_o,
  output logic [WordW-1:0] quot_o
);

  logic [WordW-1:0] rem_q, rem_d, num_q, num_d, den_q, den_d;
  logic [WordW:0]   rem_sh, rem_sub;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  // one restoring step
  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh  = {rem_q, num_q[WordW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = req_i.a;
      den_d  = req_i.b;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sub[WordW-1:0];
        num_d = {num_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WordW-1:0];
        num_d = {num_q[WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[src/baro_temp_pressure_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_i     | in  | operation, raw_sample
// out_o    | out | temperature_centi, pressure_pa, zero_divisor
// cfg_i    | in  | index, data (always ready)
//
// Each serial unit runs: launch, 32 shift steps, done, back to sequencer.
// Temperature item: 3 serial multiplies.
// Pressure item: 10 serial multiplies and one serial divide; when the
// divisor is zero the item ends before the divide.
// One item at a time; the next item is taken while a result waits in out_o.
// Reset clears calibration and fine temperature to 0.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_defines.svh"

module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  btpc_in_if.sink    in_i,
  btpc_out_if.source out_o,
  btpc_cfg_if.sink   cfg_i
);

  // configuration
  logic [47:0] temp_cal_q;
  logic [31:0] pc12_q, pc34_q, pc56_q, pc78_q;
  logic [15:0] pc9_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      pc12_q <= '0;
      pc34_q <= '0;
      pc56_q <= '0;
      pc78_q <= '0;
      pc9_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TEMP_CAL: temp_cal_q <= cfg_i.data;
        CFG_PRESS_12: pc12_q <= cfg_i.data[31:0];
        CFG_PRESS_34: pc34_q <= cfg_i.data[31:0];
        CFG_PRESS_56: pc56_q <= cfg_i.data[31:0];
        CFG_PRESS_78: pc78_q <= cfg_i.data[31:0];
        CFG_PRESS_9:  pc9_q  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'b0, temp_cal_q[15:0]};
  assign t2 = sext16(temp_cal_q[31:16]);
  assign t3 = sext16(temp_cal_q[47:32]);
  assign p1 = {16'b0, pc12_q[15:0]};
  assign p2 = sext16(pc12_q[31:16]);
  assign p3 = sext16(pc34_q[15:0]);
  assign p4 = sext16(pc34_q[31:16]);
  assign p5 = sext16(pc56_q[15:0]);
  assign p6 = sext16(pc56_q[31:16]);
  assign p7 = sext16(pc78_q[15:0]);
  assign p8 = sext16(pc78_q[31:16]);
  assign p9 = sext16(pc9_q);

  // state
  state_e      state_q, state_d;
  step_e       step_q, step_d;
  logic [31:0] raw_q, fine_q, fine_d;
  logic [31:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  logic        dbl_q, dbl_d;
  logic [31:0] rt_q, rt_d, rp_q, rp_d;
  logic        rz_q, rz_d;
  logic        in_xfer, out_load, launch, finish;

  unit_req_t   mul_req, div_req;
  logic        mul_done, div_done;
  logic [31:0] mul_res, div_res;

  btpc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_res)
  );

  btpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_res)
  );

  assign in_xfer = in_i.valid && in_i.ready;

  // step sequencer datapath
  always_comb begin
    logic [31:0] x, y;
    x = '0;
    y = '0;
    step_d  = step_q;
    fine_d  = fine_q;
    r0_d = r0_q;
    r1_d = r1_q;
    r2_d = r2_q;
    r3_d = r3_q;
    dbl_d = dbl_q;
    rt_d = rt_q;
    rp_d = rp_q;
    rz_d = rz_q;
    mul_req = '0;
    div_req = '0;
    launch = 1'b0;
    finish = 1'b0;
    if (state_q == ST_CALC) begin
      unique case (step_q)
        S_T0: begin
          mul_req = '{1'b1, (raw_q >> 3) - (t1 << 1), t2};
          step_d  = S_T1;
        end
        S_T1: begin
          r0_d    = asr(mul_res, 5'd11);
          x       = (raw_q >> 4) - t1;
          mul_req = '{1'b1, x, x};
          step_d  = S_T2;
        end
        S_T2: begin
          mul_req = '{1'b1, asr(mul_res, 5'd12), t3};
          step_d  = S_T3;
        end
        S_T3: begin
          x      = r0_q + asr(mul_res, 5'd14);
          fine_d = x;
          rt_d   = asr((x << 2) + x + K_ROUND, 5'd8);
          rp_d   = '0;
          rz_d   = 1'b0;
          finish = 1'b1;
        end
        S_P0: begin
          x       = asr(fine_q, 5'd1) - K_TOFFS;
          r0_d    = x;
          y       = asr(x, 5'd2);
          mul_req = '{1'b1, y, y};
          step_d  = S_P1;
        end
        S_P1: begin
          r1_d    = mul_res;
          mul_req = '{1'b1, asr(mul_res, 5'd11), p6};
          step_d  = S_P2;
        end
        S_P2: begin
          r2_d    = mul_res;
          mul_req = '{1'b1, r0_q, p5};
          step_d  = S_P3;
        end
        S_P3: begin
          r2_d    = asr(r2_q + (mul_res << 1), 5'd2) + (p4 << 16);
          mul_req = '{1'b1, p3, asr(r1_q, 5'd13)};
          step_d  = S_P4;
        end
        S_P4: begin
          r3_d    = asr(mul_res, 5'd3);
          mul_req = '{1'b1, p2, r0_q};
          step_d  = S_P5;
        end
        S_P5: begin
          x       = asr(r3_q + asr(mul_res, 5'd1), 5'd18);
          mul_req = '{1'b1, K_HALF + x, p1};
          step_d  = S_P6;
        end
        S_P6: begin
          x    = asr(mul_res, 5'd15);
          r0_d = x;
          if (x == '0) begin
            rt_d   = '0;
            rp_d   = '0;
            rz_d   = 1'b1;
            finish = 1'b1;
          end else begin
            mul_req = '{1'b1, (K_PBASE - raw_q) - asr(r2_q, 5'd12), K_PSCALE};
            step_d  = S_P7;
          end
        end
        S_P7: begin
          // keep the dividend in 32 bits: double before or after
          if (mul_res < K_SIGN) begin
            div_req = '{1'b1, mul_res << 1, r0_q};
            dbl_d   = 1'b0;
          end else begin
            div_req = '{1'b1, mul_res, r0_q};
            dbl_d   = 1'b1;
          end
          step_d = S_P8;
        end
        S_P8: begin
          x       = dbl_q ? (div_res << 1) : div_res;
          r1_d    = x;
          mul_req = '{1'b1, x >> 3, x >> 3};
          step_d  = S_P9;
        end
        S_P9: begin
          mul_req = '{1'b1, p9, mul_res >> 13};
          step_d  = S_P10;
        end
        S_P10: begin
          r3_d    = asr(mul_res, 5'd12);
          mul_req = '{1'b1, r1_q >> 2, p8};
          step_d  = S_P11;
        end
        S_P11: begin
          rp_d   = r1_q + asr(r3_q + asr(mul_res, 5'd13) + p7, 5'd4);
          rt_d   = '0;
          rz_d   = 1'b0;
          finish = 1'b1;
        end
        default: ;
      endcase
      launch = mul_req.start || div_req.start;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CALC;
      ST_CALC: begin
        if (launch)      state_d = ST_WAIT;
        else if (finish) state_d = ST_DONE;
      end
      ST_WAIT: if (mul_done || div_done) state_d = ST_CALC;
      ST_DONE: if (!out_o.valid || out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_DONE: out_load = !out_o.valid || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_T0;
      fine_q      <= '0;
      out_o.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      fine_q  <= fine_d;
      if (in_xfer) begin
        step_q <= (in_i.operation == OP_PRESS) ? S_P0 : S_T0;
      end else begin
        step_q <= step_d;
      end
      if (out_load)          out_o.valid <= 1'b1;
      else if (out_o.ready)  out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) raw_q <= {12'b0, in_i.raw_sample};
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
    dbl_q <= dbl_d;
    rt_q  <= rt_d;
    rp_q  <= rp_d;
    rz_q  <= rz_d;
    if (out_load) begin
      out_o.temperature_centi <= rt_q;
      out_o.pressure_pa       <= rp_q;
      out_o.zero_divisor      <= rz_q;
    end
  end

  // checks
  `BTPC_ASSERT_NEXT(a_accept_busy, in_xfer, state_q == ST_CALC, "item taken but sequencer idle")
  `BTPC_ASSERT_NOW(a_one_unit, mul_done, !div_done, "multiplier and divider finished together")
  `BTPC_ASSERT_NOW(a_zero_flag, out_o.valid && out_o.zero_divisor, out_o.pressure_pa == '0 && out_o.temperature_centi == '0, "zero divisor with nonzero result")
  `BTPC_ASSERT_NEXT(a_fine_hold, state_q == ST_IDLE && !in_xfer, $stable(fine_q), "fine temperature changed while idle")

endmodule
